// File: src/sola_pkg.sv
// Shared types and constants for the self-organizing list access block.
// No dependencies; used by sola_ctrl, sola_dp, self_organizing_list_access and the test files.
package sola_pkg;

  localparam int KEY_W    = 5;
  localparam int POS_W    = 5;
  localparam int CNT_W    = 16;
  localparam int TOTAL_W  = 32;
  localparam int POLICY_W = 2;

  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic [POLICY_W-1:0] POL_MTF       = 2'd0;
  localparam logic [POLICY_W-1:0] POL_TRANSPOSE = 2'd1;
  localparam logic [POLICY_W-1:0] POL_COUNT     = 2'd2;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;    // capture the request
    logic search;  // locate the key
    logic update;  // reorder, accumulate, emit result
  } cmd_t;

endpackage

// File: src/sola_ctrl.sv
// Sequencer for the self-organizing list access block.
// Depends on sola_pkg; drives sola_dp through sola_pkg::cmd_t.
module sola_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output sola_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SEARCH;
            busy  <= 1'b1;
          end
        end
        ST_SEARCH: begin
          state <= ST_UPDATE;
          busy  <= 1'b0;
        end
        ST_UPDATE: begin
          // next request may enter while this one updates
          if (start) begin
            state <= ST_SEARCH;
            busy  <= 1'b1;
          end else begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd.load   = start && !busy;
    cmd.search = (state == ST_SEARCH);
    cmd.update = (state == ST_UPDATE);
  end

`ifndef NO_ASSERTIONS
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than the search cycle");

  a_accept_to_search: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_SEARCH))
    else $error("accepted request did not enter search");

  a_search_to_update: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |=> (state == ST_UPDATE))
    else $error("search not followed by update");

  a_busy_matches_search: assert property (@(posedge clk) disable iff (rst)
    busy == (state == ST_SEARCH))
    else $error("busy out of step with state");
`endif

endmodule

// File: src/sola_dp.sv
// Datapath: key list with per-slot hit counters, search, reorder and cost total.
// Depends on sola_pkg; controlled by sola_ctrl through sola_pkg::cmd_t.
module sola_dp #(
  parameter int LIST_SIZE = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sola_pkg::cmd_t                   cmd,
  input  logic [sola_pkg::KEY_W-1:0]       key,
  input  logic                             last_request,
  input  logic                             cfg_write,
  input  logic [sola_pkg::POLICY_W-1:0]    cfg_data,
  output logic                             done,
  output logic [sola_pkg::POS_W-1:0]       position,
  output logic                             found,
  output logic [sola_pkg::TOTAL_W-1:0]     total_cost,
  output logic                             batch_end
);

  localparam int SLOT_W  = $clog2(LIST_SIZE);
  localparam int ENTRY_W = $clog2(LIST_SIZE + 1);
  localparam int CMP_W   = (ENTRY_W > sola_pkg::KEY_W) ? ENTRY_W : sola_pkg::KEY_W;
  localparam int CNT_W   = sola_pkg::CNT_W;
  localparam int TOT_W   = sola_pkg::TOTAL_W;

  logic [ENTRY_W-1:0] entry [LIST_SIZE];
  logic [CNT_W-1:0]   cnt   [LIST_SIZE];

  logic [sola_pkg::KEY_W-1:0]    key_q;
  logic                          last_q;
  logic [sola_pkg::POLICY_W-1:0] policy;
  logic [TOT_W-1:0]              running_total;

  logic [SLOT_W-1:0] hit_slot;
  logic              hit;
  logic [CNT_W-1:0]  hit_cnt;

  logic [ENTRY_W-1:0] key_ent;
  logic [SLOT_W-1:0]  match_slot;
  logic               match_any;
  logic [CNT_W-1:0]   match_cnt;

  logic [LIST_SIZE-1:0] le_vec;
  logic [SLOT_W-1:0]    first_le;
  logic                 any_le;
  logic [SLOT_W-1:0]    dst;
  logic                 move;

  logic [SLOT_W:0]  pos_full;
  logic [TOT_W:0]   sum;
  logic [TOT_W-1:0] total_next;

  assign key_ent = ENTRY_W'(CMP_W'(key_q));

  // parallel compare; keys are distinct so at most one slot matches
  always_comb begin
    match_slot = '0;
    match_any  = 1'b0;
    match_cnt  = '0;
    for (int i = 0; i < LIST_SIZE; i++) begin
      if (CMP_W'(entry[i]) == CMP_W'(key_q)) begin
        match_slot = SLOT_W'(i);
        match_any  = 1'b1;
        match_cnt  = cnt[i];
      end
    end
  end

  // first earlier slot whose count is not greater than the new count
  always_comb begin
    for (int i = 0; i < LIST_SIZE; i++) begin
      le_vec[i] = (SLOT_W'(i) < hit_slot) && (cnt[i] <= hit_cnt);
    end
    first_le = '0;
    any_le   = 1'b0;
    for (int i = LIST_SIZE - 1; i >= 0; i--) begin
      if (le_vec[i]) begin
        first_le = SLOT_W'(i);
        any_le   = 1'b1;
      end
    end
  end

  always_comb begin
    dst  = '0;
    move = 1'b0;
    case (policy)
      sola_pkg::POL_MTF: begin
        dst  = '0;
        move = hit && (hit_slot != '0);
      end
      sola_pkg::POL_TRANSPOSE: begin
        dst  = hit_slot - 1'b1;
        move = hit && (hit_slot != '0);
      end
      sola_pkg::POL_COUNT: begin
        dst  = first_le;
        move = hit && any_le;
      end
      default: begin
        dst  = '0;
        move = 1'b0;
      end
    endcase
  end

  always_comb begin
    pos_full = hit ? ({1'b0, hit_slot} + 1'b1) : '0;
    sum      = {1'b0, running_total} + (TOT_W + 1)'(pos_full);
    total_next = sum[TOT_W] ? sola_pkg::TOTAL_MAX : sum[TOT_W-1:0];
  end

  // list slots: each takes its own entry, its predecessor, or the hit key
  for (genvar i = 0; i < LIST_SIZE; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (rst) begin
        entry[i] <= ENTRY_W'(i + 1);
        cnt[i]   <= '0;
      end else if (cmd.update && hit) begin
        if (move && (SLOT_W'(i) == dst)) begin
          entry[i] <= key_ent;
          cnt[i]   <= hit_cnt;
        end else if (move && (SLOT_W'(i) > dst) && (SLOT_W'(i) <= hit_slot)) begin
          if (i > 0) begin
            entry[i] <= entry[(i > 0) ? i - 1 : 0];
            cnt[i]   <= cnt[(i > 0) ? i - 1 : 0];
          end
        end else if (!move && (SLOT_W'(i) == hit_slot)) begin
          cnt[i] <= hit_cnt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q  <= key;
      last_q <= last_request;
    end
    if (cmd.search) begin
      hit_slot <= match_slot;
      hit_cnt  <= (match_cnt == sola_pkg::CNT_MAX) ? match_cnt : match_cnt + 1'b1;
    end
    if (cmd.update) begin
      position   <= sola_pkg::POS_W'(pos_full);
      found      <= hit;
      total_cost <= total_next;
      batch_end  <= last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy        <= sola_pkg::POL_MTF;
      running_total <= '0;
      hit           <= 1'b0;
      done          <= 1'b0;
    end else begin
      if (cfg_write) begin
        policy <= cfg_data;
      end
      if (cmd.search) begin
        hit <= match_any;
      end
      if (cmd.update) begin
        running_total <= last_q ? '0 : total_next;
      end
      done <= cmd.update;
    end
  end

endmodule

// File: src/self_organizing_list_access.sv
// Self-organizing list access unit: accepts one key request on start while busy is
// low and returns one result, marked by done for exactly one cycle, after the request
// has passed a parallel compare over the list and then a one-step shift of the list
// slots; a new request may be issued while the previous one is in its shift step, and
// busy is high only during the compare step. The result cannot be held off.
// The policy register (0 move-to-front, 1 transpose, 2 count) is written through
// cfg_valid/cfg_data, always ready; write it only while no request is in flight.
// Depends on sola_pkg, sola_ctrl and sola_dp.
module self_organizing_list_access #(
  parameter int LIST_SIZE = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [sola_pkg::KEY_W-1:0]        key,
  input  logic                              last_request,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sola_pkg::POLICY_W-1:0]     cfg_data,
  output logic                              done,
  output logic [sola_pkg::POS_W-1:0]        position,
  output logic                              found,
  output logic [sola_pkg::TOTAL_W-1:0]      total_cost,
  output logic                              batch_end
);

  sola_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  sola_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  sola_dp #(
    .LIST_SIZE (LIST_SIZE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .key          (key),
    .last_request (last_request),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .done         (done),
    .position     (position),
    .found        (found),
    .total_cost   (total_cost),
    .batch_end    (batch_end)
  );

endmodule

// File: test/self_organizing_list_access_checker.sv
// Checker for the self-organizing list access unit: tracks list order, hit counters,
// batch cost and policy, predicts each result and compares it with what done marks.
// Depends on sola_pkg.
`timescale 1ns / 1ps
module self_organizing_list_access_checker #(
  parameter int LIST_SIZE = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [sola_pkg::KEY_W-1:0]    key,
  input  logic                          last_request,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [sola_pkg::POLICY_W-1:0] cfg_data,
  input  logic                          done,
  input  logic [sola_pkg::POS_W-1:0]    position,
  input  logic                          found,
  input  logic [sola_pkg::TOTAL_W-1:0]  total_cost,
  input  logic                          batch_end,
  output int                            mismatches,
  output int                            in_flight,
  output int                            compared
);

  typedef struct packed {
    logic [sola_pkg::POS_W-1:0]   position;
    logic                         found;
    logic [sola_pkg::TOTAL_W-1:0] total;
    logic                         batch_end;
  } access_t;

  logic [sola_pkg::KEY_W-1:0]    order_q [LIST_SIZE];
  logic [sola_pkg::CNT_W-1:0]    hits_q [LIST_SIZE];
  logic [sola_pkg::TOTAL_W-1:0]  batch_cost;
  logic [sola_pkg::POLICY_W-1:0] policy_q;
  access_t                       expected_access [$];

  initial begin
    mismatches = 0;
    in_flight = 0;
    compared = 0;
  end

  function automatic void flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: result %0d: %s", $time, compared, msg);
  endfunction

  // Look up the key, bump its counter and cost, reorder the list.
  function automatic access_t predict_access(input logic [sola_pkg::KEY_W-1:0] k,
                                             input logic lastr);
    int                         slot;
    int                         dst;
    logic                       hit;
    logic [sola_pkg::CNT_W-1:0] cnt;
    logic [sola_pkg::KEY_W-1:0] moved;
    access_t                    res;
    hit = 1'b0;
    slot = 0;
    res = '0;
    for (int i = 0; i < LIST_SIZE; i++)
      if (!hit && order_q[i] == k) begin
        hit = 1'b1;
        slot = i;
      end
    if (hit) begin
      if (hits_q[k - 1] != sola_pkg::CNT_MAX) hits_q[k - 1] = hits_q[k - 1] + 1'b1;
      cnt = hits_q[k - 1];
      res.position = sola_pkg::POS_W'(slot + 1);
      dst = slot;
      if (slot != 0) begin
        case (policy_q)
          sola_pkg::POL_MTF:       dst = 0;
          sola_pkg::POL_TRANSPOSE: dst = slot - 1;
          sola_pkg::POL_COUNT: begin
            for (int q = 0; q < slot; q++)
              if (dst == slot && hits_q[order_q[q] - 1] <= cnt) dst = q;
          end
          default:                 dst = slot;
        endcase
      end
      moved = order_q[slot];
      for (int i = slot; i > dst; i--) order_q[i] = order_q[i - 1];
      order_q[dst] = moved;
      if (batch_cost > sola_pkg::TOTAL_MAX - res.position) batch_cost = sola_pkg::TOTAL_MAX;
      else batch_cost = batch_cost + res.position;
    end
    res.found = hit;
    res.total = batch_cost;
    res.batch_end = lastr;
    if (lastr) batch_cost = '0;
    return res;
  endfunction

  always @(posedge clk) begin
    access_t want;
    access_t got;
    if (rst) begin
      for (int i = 0; i < LIST_SIZE; i++) begin
        order_q[i] = sola_pkg::KEY_W'(i + 1);
        hits_q[i] = '0;
      end
      batch_cost = '0;
      policy_q = sola_pkg::POL_MTF;
      expected_access.delete();
    end else begin
      if (done) begin
        got = '{position, found, total_cost, batch_end};
        if (expected_access.size() == 0) begin
          flag($sformatf("unexpected result, position %0d total %0d",
                         got.position, got.total));
        end else begin
          want = expected_access.pop_front();
          if (got.position !== want.position)
            flag($sformatf("position expected %0d, got %0d", want.position, got.position));
          if (got.found !== want.found)
            flag($sformatf("found expected %0d, got %0d", want.found, got.found));
          if (got.total !== want.total)
            flag($sformatf("total_cost expected %0d, got %0d", want.total, got.total));
          if (got.batch_end !== want.batch_end)
            flag($sformatf("batch_end expected %0d, got %0d", want.batch_end, got.batch_end));
          compared++;
        end
      end
      if (cfg_valid && cfg_ready) policy_q = cfg_data;
      if (start && !busy) expected_access.push_back(predict_access(key, last_request));
    end
    in_flight <= expected_access.size();
  end

endmodule

// File: test/self_organizing_list_access_test.sv
// Testbench top for self_organizing_list_access: drives directed and random key
// requests and policy writes; self_organizing_list_access_checker predicts and compares.
// Depends on sola_pkg, the block and the checker.
`timescale 1ns / 1ps
module self_organizing_list_access_test;

  localparam int LIST_SIZE = 16;
  localparam int STALL_LIMIT = 500;
  localparam int PHASES = 6;
  localparam int PHASE_REQUESTS = 250;
  localparam logic [sola_pkg::POLICY_W-1:0] POL_UNUSED = 2'd3;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [sola_pkg::KEY_W-1:0]    key;
  logic                          last_request;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [sola_pkg::POLICY_W-1:0] cfg_data;
  logic                          done;
  logic [sola_pkg::POS_W-1:0]    position;
  logic                          found;
  logic [sola_pkg::TOTAL_W-1:0]  total_cost;
  logic                          batch_end;

  int   mismatches;
  int   in_flight;
  int   compared;
  int   requests_sent = 0;
  int   config_writes = 0;
  int   stall_cycles = 0;
  int   hot_base = 1;
  logic quiet_phase = 1'b0;

  self_organizing_list_access #(.LIST_SIZE(LIST_SIZE)) uut (.*);

  self_organizing_list_access_checker #(.LIST_SIZE(LIST_SIZE)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results pending",
               STALL_LIMIT, in_flight);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic issue(input logic [sola_pkg::KEY_W-1:0] k, input logic lastr);
    start <= 1'b1;
    key <= k;
    last_request <= lastr;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
  endtask

  task automatic idle_gap();
    if (!quiet_phase && $urandom_range(99) < 31) begin
      start <= 1'b0;
      key <= sola_pkg::KEY_W'($urandom);
      last_request <= 1'($urandom);
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic set_policy(input logic [sola_pkg::POLICY_W-1:0] p);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= p;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    config_writes++;
  endtask

  // Mostly a small hot set so the count policy sees real frequency skew.
  function automatic logic [sola_pkg::KEY_W-1:0] pick_key();
    int r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 55) return sola_pkg::KEY_W'(hot_base + $urandom_range(3, 0));
    return sola_pkg::KEY_W'($urandom_range(LIST_SIZE, 1));
  endfunction

  initial begin
    rst = 1'b1;
    start = 1'b0;
    key = '0;
    last_request = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // move-to-front after reset: head, tail, absent, batch ends
    issue(1, 0);
    issue(16, 0);
    issue(0, 0);
    issue(16, 0);
    issue(8, 1);
    issue(0, 1);
    set_policy(sola_pkg::POL_TRANSPOSE);
    issue(1, 0);
    issue(1, 0);
    issue(15, 0);
    issue(8, 0);
    issue(16, 1);
    set_policy(sola_pkg::POL_COUNT);
    issue(12, 0);
    issue(12, 0);
    issue(3, 0);
    issue(3, 0);
    issue(3, 0);
    issue(9, 0);
    issue(12, 1);
    set_policy(POL_UNUSED);
    issue(14, 0);
    issue(2, 0);
    issue(0, 1);

    for (int ph = 0; ph < PHASES; ph++) begin
      set_policy(sola_pkg::POLICY_W'($urandom_range(3)));
      quiet_phase = (ph == 2);
      hot_base = $urandom_range(LIST_SIZE - 3, 1);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        issue(pick_key(), $urandom_range(9) == 0);
        if (ph == 0 && i == PHASE_REQUESTS / 2) drain();
        idle_gap();
      end
    end

    // count policy over a skewed mix on an already reordered list
    set_policy(sola_pkg::POL_COUNT);
    quiet_phase = 1'b0;
    hot_base = 4;
    for (int i = 0; i < PHASE_REQUESTS; i++) begin
      issue(pick_key(), $urandom_range(9) == 0);
      idle_gap();
    end

    start <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d requests, compared %0d results, %0d policy writes over all four codes,",
             requests_sent, compared, config_writes);
    $display("with absent keys, batch ends, idle gaps, a full drain and skewed key mixes.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
